// ===== rtl/dfifo_pkg.sv =====
package dfifo_pkg;

  localparam int unsigned KEY_BITS_DEF = 11;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned KEY_W    = 11;
  localparam int unsigned CELL_W   = 7;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned REASON_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 12;

  localparam logic [REQ_W-1:0] REQ_PUSH     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [KEY_W-1:0]    event_key;
    logic                event_kind;
    logic [CELL_W-1:0]   cell_index;
    logic [DIGIT_W-1:0]  digit_value;
    logic [REASON_W-1:0] reason_code;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic                kind;
    logic [CELL_W-1:0]   cell_idx;
    logic [DIGIT_W-1:0]  digit;
    logic [REASON_W-1:0] reason;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    entry_t              head;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } rsp_t;

  typedef struct packed {
    logic clr_en;
    logic cap;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/dfifo_if.sv =====
interface dfifo_req_if import dfifo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [KEY_W-1:0]    event_key;
  logic                event_kind;
  logic [CELL_W-1:0]   cell_index;
  logic [DIGIT_W-1:0]  digit_value;
  logic [REASON_W-1:0] reason_code;

  modport source (
    output valid, req_type, event_key, event_kind, cell_index, digit_value, reason_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, event_key, event_kind, cell_index, digit_value, reason_code,
    output ready
  );
endinterface

interface dfifo_rsp_if import dfifo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [KEY_W-1:0]    head_key;
  logic                head_kind;
  logic [CELL_W-1:0]   head_cell;
  logic [DIGIT_W-1:0]  head_digit;
  logic [REASON_W-1:0] head_reason;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;

  modport source (
    output valid, status, found, head_key, head_kind, head_cell, head_digit, head_reason,
           count, is_empty,
    input  ready
  );
  modport sink (
    input  valid, status, found, head_key, head_kind, head_cell, head_digit, head_reason,
           count, is_empty,
    output ready
  );
endinterface

// ===== rtl/dfifo_ctrl.sv =====
module dfifo_ctrl import dfifo_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the new word
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_cap_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |=> state_q == S_EXEC)
    else $error("capture not followed by execute");
  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !sts_i.out_free) |=> state_q == S_EXEC)
    else $error("execute left while result register full");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!req_ready_o && !cmd_o.cap && !cmd_o.commit))
    else $error("request handled during the clear pass");
`endif

endmodule

// ===== rtl/dfifo_dp.sv =====
module dfifo_dp import dfifo_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  input  req_t    req_i,
  input  logic    rsp_ready_i,
  output logic    rsp_valid_o,
  output rsp_t    rsp_o
);

  localparam int unsigned DEPTH = 1 << KEY_BITS;
  localparam int unsigned CNT_W = KEY_BITS + 1;

  entry_t entry_mem   [DEPTH];
  logic   present_mem [DEPTH];

  logic [KEY_BITS-1:0] head_q, head_d;
  logic [KEY_BITS-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [KEY_BITS-1:0] clr_q;
  logic                rsp_valid_q;

  req_t   rq_q;
  entry_t ent_rd_q;
  logic   pm_rd_q;
  rsp_t   rsp_q, rsp_d;

  logic [KEY_BITS-1:0] rq_key;
  logic                cnt_zero;
  entry_t              new_ent;
  entry_t              show;
  logic                ent_wr, pm_wr;
  logic                ent_we, pm_we;
  logic [KEY_BITS-1:0] pm_waddr;
  logic                pm_wdata;
  logic                found;
  logic [STATUS_W-1:0] status;

  always_comb begin
    rq_key   = KEY_BITS'(rq_q.event_key);
    cnt_zero = (cnt_q == '0);
    new_ent  = '{key: KEY_W'(rq_key), kind: rq_q.event_kind, cell_idx: rq_q.cell_index,
                 digit: rq_q.digit_value, reason: rq_q.reason_code};
    show     = cnt_zero ? '0 : ent_rd_q;
    status   = ST_DONE;
    found    = 1'b0;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    ent_wr   = 1'b0;
    pm_wr    = 1'b0;
    pm_waddr = rq_key;
    pm_wdata = 1'b0;

    unique case (rq_q.req_type)
      REQ_PUSH: begin
        if (pm_rd_q) begin
          status = ST_DUP;
        end else begin
          ent_wr   = 1'b1;
          pm_wr    = 1'b1;
          pm_wdata = 1'b1;
          tail_d   = tail_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
          // the pushed word becomes the head of an empty queue
          if (cnt_zero) begin
            show = new_ent;
          end
        end
      end
      REQ_POP: begin
        if (cnt_zero) begin
          status = ST_EMPTY;
          show   = '0;
        end else begin
          pm_wr    = 1'b1;
          pm_waddr = KEY_BITS'(ent_rd_q.key);
          head_d   = head_q + 1'b1;
          cnt_d    = cnt_q - 1'b1;
          show     = ent_rd_q;
        end
      end
      REQ_CONTAINS: begin
        found = pm_rd_q;
      end
      default: begin
        found = 1'b0;
      end
    endcase

    ent_we = cmd_i.commit && ent_wr;
    pm_we  = cmd_i.commit && pm_wr;
    if (cmd_i.clr_en) begin
      pm_we    = 1'b1;
      pm_waddr = clr_q;
      pm_wdata = 1'b0;
    end

    rsp_d.status   = status;
    rsp_d.found    = found;
    rsp_d.head     = show;
    rsp_d.count    = COUNT_W'(cnt_d);
    rsp_d.is_empty = (cnt_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[tail_q] <= new_ent;
    end
    if (cmd_i.cap) begin
      ent_rd_q <= entry_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      present_mem[pm_waddr] <= pm_wdata;
    end
    if (cmd_i.cap) begin
      pm_rd_q <= present_mem[KEY_BITS'(req_i.event_key)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      rq_q <= req_i;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.commit) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_q == '1);
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_o          = rsp_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above queue depth");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) == ((cnt_q == '0) || (cnt_q == CNT_W'(DEPTH))))
    else $error("pointers disagree with entry count");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> sts_o.out_free)
    else $error("commit while result register is full");
`endif

endmodule

// ===== rtl/dedup_event_fifo_core.sv =====
// channel  dir  handshake     word
// req_i    in   valid/ready   req_type, event_key, event_kind, cell_index, digit_value,
//                             reason_code
// rsp_o    out  valid/ready   status, found, head_*, count, is_empty
//
// After reset the key-presence map is cleared, one entry a cycle, all 2^KEY_BITS entries
// (2048 by default); req_i.ready stays low during that pass.
// On accept the request, the entry store read at the head and the presence map read
// at the key are registered; in the execute step, once the result register is free,
// the update commits and the result register loads; only then is a new request taken.
// A stalled rsp_o holds its word; the next request is still accepted and waits
// in the execute step until the result register frees.
module dedup_event_fifo_core import dfifo_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfifo_req_if.sink   req_i,
  dfifo_rsp_if.source rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  req_t    req_word;
  rsp_t    rsp_word;
  logic    rsp_valid;

  assign req_word = '{req_type: req_i.req_type, event_key: req_i.event_key,
                      event_kind: req_i.event_kind, cell_index: req_i.cell_index,
                      digit_value: req_i.digit_value, reason_code: req_i.reason_code};

  dfifo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dfifo_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_word),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_word)
  );

  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.status      = rsp_word.status;
  assign rsp_o.found       = rsp_word.found;
  assign rsp_o.head_key    = rsp_word.head.key;
  assign rsp_o.head_kind   = rsp_word.head.kind;
  assign rsp_o.head_cell   = rsp_word.head.cell_idx;
  assign rsp_o.head_digit  = rsp_word.head.digit;
  assign rsp_o.head_reason = rsp_word.head.reason;
  assign rsp_o.count       = rsp_word.count;
  assign rsp_o.is_empty    = rsp_word.is_empty;

endmodule
